// ===== rtl/core/scm_pkg.sv =====
`default_nettype none

package scm_pkg;

  // Default upper bound on emitted channels per frame
  localparam int MAX_OUT_CHANNELS_DEF = 8;

  // Field widths
  localparam int SAMPLE_IN_W  = 16;
  localparam int SAMPLE_OUT_W = 32;
  localparam int CHAN_W       = 3;
  localparam int CNT_W        = 4;
  localparam int LAYOUT_W     = 3;
  localparam int FORMAT_W     = 2;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 8;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_LAYOUT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_FORMAT  = 2'd1;

  // Layout codes
  localparam logic [LAYOUT_W-1:0] LAYOUT_MONO   = 3'd0;
  localparam logic [LAYOUT_W-1:0] LAYOUT_STEREO = 3'd1;
  localparam logic [LAYOUT_W-1:0] LAYOUT_QUAD   = 3'd2;
  localparam logic [LAYOUT_W-1:0] LAYOUT_5_1    = 3'd3;
  localparam logic [LAYOUT_W-1:0] LAYOUT_7_1    = 3'd4;

  // Sample format codes
  localparam logic [FORMAT_W-1:0] FMT_INT16 = 2'd0;
  localparam logic [FORMAT_W-1:0] FMT_INT24 = 2'd1;
  localparam logic [FORMAT_W-1:0] FMT_INT32 = 2'd2;

  // Channel source codes
  localparam logic [1:0] SRC_LEFT   = 2'd0;
  localparam logic [1:0] SRC_RIGHT  = 2'd1;
  localparam logic [1:0] SRC_SILENT = 2'd2;
  localparam logic [1:0] SRC_MEAN   = 2'd3;

  typedef struct packed {
    logic signed [SAMPLE_IN_W-1:0] left_sample;
    logic signed [SAMPLE_IN_W-1:0] right_sample;
  } frame_t;

  typedef struct packed {
    logic signed [SAMPLE_OUT_W-1:0] sample_value;
    logic [CHAN_W-1:0]              channel_index;
    logic                           last_of_frame;
  } result_t;

  // Handoff from the top level to the serializer
  typedef struct packed {
    logic             load;
    logic [CNT_W-1:0] count;
  } frame_ctl_t;

  // Source of one output channel in a given layout
  function automatic logic [1:0] layout_src(input logic [LAYOUT_W-1:0] lay,
                                            input logic [CHAN_W-1:0] ch);
    logic [1:0] src;
    src = ch[0] ? SRC_RIGHT : SRC_LEFT;
    case (lay)
      LAYOUT_MONO: src = SRC_MEAN;
      LAYOUT_5_1, LAYOUT_7_1: begin
        if (ch == 3'd2) src = SRC_SILENT;
        else if (ch == 3'd3) src = SRC_MEAN;
      end
      default: ;
    endcase
    return src;
  endfunction

  // Channels per frame in a given layout
  function automatic logic [CNT_W-1:0] layout_count(input logic [LAYOUT_W-1:0] lay);
    logic [CNT_W-1:0] n;
    case (lay)
      LAYOUT_MONO: n = 4'd1;
      LAYOUT_QUAD: n = 4'd4;
      LAYOUT_5_1:  n = 4'd6;
      LAYOUT_7_1:  n = 4'd8;
      default:     n = 4'd2;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/scm_lane.sv =====
`default_nettype none

module scm_lane #(
  parameter int LANE = 0
) (
  input  wire logic [scm_pkg::LAYOUT_W-1:0]           layout,
  input  wire logic [scm_pkg::FORMAT_W-1:0]           format,
  input  wire logic signed [scm_pkg::SAMPLE_IN_W-1:0] left,
  input  wire logic signed [scm_pkg::SAMPLE_IN_W-1:0] right,
  input  wire logic signed [scm_pkg::SAMPLE_IN_W-1:0] mean,
  output logic signed [scm_pkg::SAMPLE_OUT_W-1:0]     sample
);
  import scm_pkg::*;

  logic signed [SAMPLE_IN_W-1:0] picked;

  // Pick this channel's source
  always_comb begin
    case (layout_src(layout, CHAN_W'(LANE)))
      SRC_LEFT:  picked = left;
      SRC_RIGHT: picked = right;
      SRC_MEAN:  picked = mean;
      default:   picked = '0;
    endcase
  end

  // Widen to the output format, left-justified for int24 and int32
  always_comb begin
    case (format)
      FMT_INT24: sample = {{8{picked[SAMPLE_IN_W-1]}}, picked, 8'd0};
      FMT_INT32: sample = {picked, 16'd0};
      default:   sample = {{16{picked[SAMPLE_IN_W-1]}}, picked};
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/scm_serializer.sv =====
`default_nettype none

module scm_serializer #(
  parameter int MAX_OUT_CHANNELS = scm_pkg::MAX_OUT_CHANNELS_DEF
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire scm_pkg::frame_ctl_t                     ctl,
  input  wire logic signed [scm_pkg::SAMPLE_OUT_W-1:0] lane_samples [MAX_OUT_CHANNELS],
  output logic                                         busy,
  output logic                                         strobe,
  output scm_pkg::result_t                             result
);
  import scm_pkg::*;

  localparam int IDX_W = (MAX_OUT_CHANNELS > 1) ? $clog2(MAX_OUT_CHANNELS) : 1;

  logic                           hold_valid;
  logic [CNT_W-1:0]               hold_count;
  logic signed [SAMPLE_OUT_W-1:0] hold_samples [MAX_OUT_CHANNELS];

  logic                           emit_valid;
  logic [CNT_W-1:0]               emit_count;
  logic [CHAN_W-1:0]              emit_idx;
  logic signed [SAMPLE_OUT_W-1:0] emit_samples [MAX_OUT_CHANNELS];

  logic emit_last;
  logic emit_free;

  assign emit_last = emit_valid && (({1'b0, emit_idx} + 4'd1) == emit_count);
  assign emit_free = !emit_valid || emit_last;
  assign busy      = hold_valid && !emit_free;

  // Control: when the current frame finishes, move hold (or else a new frame) into emit
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      emit_valid <= 1'b0;
      emit_idx   <= '0;
    end else if (emit_free) begin
      if (hold_valid) begin
        emit_valid <= 1'b1;
        emit_idx   <= '0;
        hold_valid <= ctl.load;
      end else if (ctl.load) begin
        emit_valid <= 1'b1;
        emit_idx   <= '0;
      end else begin
        emit_valid <= 1'b0;
      end
    end else begin
      emit_idx <= emit_idx + 3'd1;
      if (ctl.load) hold_valid <= 1'b1;
    end
  end

  // Payload: fill hold or emit buffers
  always_ff @(posedge clk) begin
    if (emit_free && hold_valid) begin
      emit_samples <= hold_samples;
      emit_count   <= hold_count;
    end else if (emit_free && ctl.load) begin
      emit_samples <= lane_samples;
      emit_count   <= ctl.count;
    end
    if (ctl.load && (hold_valid || !emit_free)) begin
      hold_samples <= lane_samples;
      hold_count   <= ctl.count;
    end
  end

  // Present one channel per cycle
  assign strobe               = emit_valid;
  assign result.sample_value  = emit_samples[emit_idx[IDX_W-1:0]];
  assign result.channel_index = emit_idx;
  assign result.last_of_frame = emit_last;

endmodule

`default_nettype wire

// ===== rtl/core/stereo_channel_mapper_formatter.sv =====
`default_nettype none
// Channel   Direction  Transfer                    Payload
// command   in         start && !busy              frame  (scm_pkg::frame_t)
// result    out        strobe                      result (scm_pkg::result_t)
// config    in         cfg_valid && cfg_ready      cfg_index, cfg_data
//
// All output channels of a frame are computed at once by parallel lanes;
// the serializer then emits one channel per cycle, one result for each
// channel of its layout (1 to MAX_OUT_CHANNELS). A command goes to the
// emit buffer if that is free and nothing is held, else to the hold one.
// A second frame is buffered while the first is emitted; busy rises only
// when that buffer is full. Synchronous reset sets stereo and int16.
// The receiver cannot stall; results are shown for exactly one cycle.

module stereo_channel_mapper_formatter #(
  parameter int MAX_OUT_CHANNELS = scm_pkg::MAX_OUT_CHANNELS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire scm_pkg::frame_t                 frame,
  output logic                                 strobe,
  output scm_pkg::result_t                     result,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [scm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [scm_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import scm_pkg::*;

  logic [LAYOUT_W-1:0] channel_layout;
  logic [FORMAT_W-1:0] sample_format;

  logic [LAYOUT_W-1:0]            layout_eff;
  logic [CNT_W-1:0]               layout_n;
  logic signed [SAMPLE_IN_W:0]    pair_sum;
  logic signed [SAMPLE_IN_W:0]    pair_adj;
  logic signed [SAMPLE_IN_W-1:0]  mean;
  logic signed [SAMPLE_OUT_W-1:0] lane_samples [MAX_OUT_CHANNELS];
  frame_ctl_t                     ctl;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_layout <= LAYOUT_STEREO;
      sample_format  <= FMT_INT16;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CHANNEL_LAYOUT: channel_layout <= cfg_data[LAYOUT_W-1:0];
        REG_SAMPLE_FORMAT:  sample_format  <= cfg_data[FORMAT_W-1:0];
        default: ;
      endcase
    end
  end

  // Unused layout codes fall back to stereo
  assign layout_eff = (channel_layout > LAYOUT_7_1) ? LAYOUT_STEREO : channel_layout;
  assign layout_n   = layout_count(layout_eff);

  // Mean of left and right, truncating toward zero
  assign pair_sum = {frame.left_sample[SAMPLE_IN_W-1], frame.left_sample}
                  + {frame.right_sample[SAMPLE_IN_W-1], frame.right_sample};
  assign pair_adj = pair_sum + (SAMPLE_IN_W+1)'(pair_sum[SAMPLE_IN_W]);
  assign mean     = pair_adj[SAMPLE_IN_W:1];

  // One lane per output channel
  for (genvar g = 0; g < MAX_OUT_CHANNELS; g++) begin : g_lane
    scm_lane #(.LANE(g)) u_lane (
      .layout (layout_eff),
      .format (sample_format),
      .left   (frame.left_sample),
      .right  (frame.right_sample),
      .mean   (mean),
      .sample (lane_samples[g])
    );
  end

  // Clip the channel count to the lanes present
  assign ctl.load  = start && !busy;
  assign ctl.count = (layout_n > CNT_W'(MAX_OUT_CHANNELS)) ? CNT_W'(MAX_OUT_CHANNELS)
                                                           : layout_n;

  scm_serializer #(.MAX_OUT_CHANNELS(MAX_OUT_CHANNELS)) u_serializer (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .lane_samples (lane_samples),
    .busy         (busy),
    .strobe       (strobe),
    .result       (result)
  );

  // A frame's channels come out in consecutive cycles
  a_frame_contiguous: assert property (@(posedge clk) disable iff (rst)
    strobe && !result.last_of_frame |=> strobe)
    else $error("frame emission broke off before its last channel");

  a_index_advance: assert property (@(posedge clk) disable iff (rst)
    strobe && !result.last_of_frame |=>
      result.channel_index == $past(result.channel_index) + 3'd1)
    else $error("channel index did not advance by one");

  a_busy_only_emitting: assert property (@(posedge clk) disable iff (rst)
    !strobe |-> !busy)
    else $error("busy while nothing is being emitted");

  a_index_bound: assert property (@(posedge clk) disable iff (rst)
    strobe |-> ({1'b0, result.channel_index} < CNT_W'(MAX_OUT_CHANNELS)))
    else $error("channel index beyond lane count");

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import scm_pkg::*;

  localparam int NUM_DIRECTED     = 24;
  localparam int RANDOM_PER_PHASE = 82;
  localparam int SETTLE_CYCLES    = 4;
  localparam int DRAIN_CYCLES     = 16;
  localparam int STALL_LIMIT      = 2000;
  localparam int MAX_REPORTS      = 10;

  // Codes outside the defined ranges
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI    = 2'd3;
  localparam logic [LAYOUT_W-1:0]  LAYOUT_UNUSED_5 = 3'd5;
  localparam logic [LAYOUT_W-1:0]  LAYOUT_UNUSED_6 = 3'd6;
  localparam logic [LAYOUT_W-1:0]  LAYOUT_UNUSED_7 = 3'd7;
  localparam logic [FORMAT_W-1:0]  FMT_UNUSED      = 2'd3;

  // One directed frame with the settings it runs under
  typedef struct packed {
    logic [CFG_DATA_W-1:0] lay_data;
    logic [CFG_DATA_W-1:0] fmt_data;
    logic [15:0]           left;
    logic [15:0]           right;
    logic                  typed;
    logic [31:0]           want0;
    logic [31:0]           want1;
  } drive_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  frame_t frame = '0;
  logic strobe;
  result_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Settings as the block should hold them
  logic [LAYOUT_W-1:0] cur_layout = LAYOUT_STEREO;
  logic [FORMAT_W-1:0] cur_format = FMT_INT16;

  result_t expected_samples[$];
  int mismatches = 0;
  int stall_cycles = 0;

  drive_row_t directed [NUM_DIRECTED];

  stereo_channel_mapper_formatter i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .frame     (frame),
    .strobe    (strobe),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Append one sample to the tail of the pending list
  function automatic void add_expected(input result_t item);
    expected_samples.insert(expected_samples.size(), item);
  endfunction

  // Channels emitted per frame; unused codes fall back to stereo
  function automatic int channel_count(input logic [LAYOUT_W-1:0] lay);
    case (lay)
      LAYOUT_MONO: return 1;
      LAYOUT_QUAD: return 4;
      LAYOUT_5_1:  return 6;
      LAYOUT_7_1:  return 8;
      default:     return 2;
    endcase
  endfunction

  // Source of each channel, two bits per channel with channel 0 lowest
  function automatic logic [1:0] channel_source(input logic [LAYOUT_W-1:0] lay,
                                                input int ch);
    logic [15:0] map;
    case (lay)
      LAYOUT_MONO: map = {14'd0, SRC_MEAN};
      LAYOUT_QUAD: map = {8'd0, SRC_RIGHT, SRC_LEFT, SRC_RIGHT, SRC_LEFT};
      LAYOUT_5_1:  map = {4'd0, SRC_RIGHT, SRC_LEFT, SRC_MEAN, SRC_SILENT,
                          SRC_RIGHT, SRC_LEFT};
      LAYOUT_7_1:  map = {SRC_RIGHT, SRC_LEFT, SRC_RIGHT, SRC_LEFT, SRC_MEAN,
                          SRC_SILENT, SRC_RIGHT, SRC_LEFT};
      default:     map = {12'd0, SRC_RIGHT, SRC_LEFT};
    endcase
    return map[2*ch +: 2];
  endfunction

  // Queue the samples one frame produces under the current settings
  function automatic void map_frame(input frame_t f);
    int l;
    int r;
    int m;
    int s;
    int n;
    logic [31:0] w;
    result_t item;
    l = $signed(f.left_sample);
    r = $signed(f.right_sample);
    m = (l + r) / 2;
    n = channel_count(cur_layout);
    for (int j = 0; j < n; j++) begin
      case (channel_source(cur_layout, j))
        SRC_LEFT:  s = l;
        SRC_RIGHT: s = r;
        SRC_MEAN:  s = m;
        default:   s = 0;
      endcase
      w = s;
      case (cur_format)
        FMT_INT24: w = w << 8;
        FMT_INT32: w = w << 16;
        default:   ;
      endcase
      item.sample_value  = w;
      item.channel_index = 3'(j);
      item.last_of_frame = (j == n - 1);
      add_expected(item);
    end
  endfunction

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'hFFFF;
      3: return 16'($urandom_range(3));
      4: return -16'($urandom_range(3));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("mismatch %s: expected %h, got %h", what, want, got);
  endtask

  // Hold start until the block takes the frame
  task automatic send_frame(input frame_t f, input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    frame <= f;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Leaves cfg_valid high; the caller drops it after the last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_CHANNEL_LAYOUT) cur_layout = data[LAYOUT_W-1:0];
    else if (idx == REG_SAMPLE_FORMAT) cur_format = data[FORMAT_W-1:0];
  endtask

  // Drain the block, then write both registers and one unused index
  task automatic configure(input logic [CFG_DATA_W-1:0] lay_data,
                           input logic [CFG_DATA_W-1:0] fmt_data);
    start <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(REG_CHANNEL_LAYOUT, lay_data);
    write_reg(REG_SAMPLE_FORMAT, fmt_data);
    write_reg($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO, 8'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // Compare each transfer with the oldest pending sample
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && strobe === 1'b1) begin
      if (expected_samples.size() == 0) begin
        report_mismatch($sformatf("unexpected sample on channel %0d",
                                  result.channel_index), 'x, result.sample_value);
      end else begin
        want = expected_samples.pop_front();
        if (result.sample_value !== want.sample_value)
          report_mismatch($sformatf("sample_value ch %0d", want.channel_index),
                          want.sample_value, result.sample_value);
        if (result.channel_index !== want.channel_index)
          report_mismatch("channel_index", 32'(want.channel_index),
                          32'(result.channel_index));
        if (result.last_of_frame !== want.last_of_frame)
          report_mismatch($sformatf("last_of_frame ch %0d", want.channel_index),
                          32'(want.last_of_frame), 32'(result.last_of_frame));
      end
    end
  end

  // End the run when nothing transfers for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    frame_t f;
    logic [CFG_DATA_W-1:0] lay_now;
    logic [CFG_DATA_W-1:0] fmt_now;
    logic [CFG_DATA_W-1:0] junk;
    logic [LAYOUT_W-1:0] lay;
    int idle_pct;
    result_t item;

    // Extremes, rounding of the mean, every layout and format, unused codes
    directed = '{
      '{8'(LAYOUT_STEREO), 8'(FMT_INT16), 16'h7FFF, 16'h8000, 1'b1,
        32'h0000_7FFF, 32'hFFFF_8000},
      '{8'(LAYOUT_STEREO), 8'(FMT_INT16), 16'h0000, 16'hFFFF, 1'b1,
        32'h0000_0000, 32'hFFFF_FFFF},
      '{8'(LAYOUT_MONO), 8'(FMT_INT16), 16'h7FFF, 16'h7FFF, 1'b1,
        32'h0000_7FFF, 32'h0},
      '{8'(LAYOUT_MONO), 8'(FMT_INT16), 16'h8000, 16'h8000, 1'b1,
        32'hFFFF_8000, 32'h0},
      '{8'(LAYOUT_MONO), 8'(FMT_INT16), 16'hFFFF, 16'h0000, 1'b1,
        32'h0000_0000, 32'h0},
      '{8'(LAYOUT_MONO), 8'(FMT_INT16), 16'h0001, 16'h0000, 1'b1,
        32'h0000_0000, 32'h0},
      '{8'(LAYOUT_MONO), 8'(FMT_INT16), 16'hFFFD, 16'h0000, 1'b1,
        32'hFFFF_FFFF, 32'h0},
      '{8'(LAYOUT_MONO), 8'(FMT_INT16), 16'h7FFF, 16'h8000, 1'b1,
        32'h0000_0000, 32'h0},
      '{8'(LAYOUT_MONO), 8'(FMT_INT16), 16'h0003, 16'h0000, 1'b1,
        32'h0000_0001, 32'h0},
      '{8'(LAYOUT_MONO), 8'(FMT_INT24), 16'h7FFF, 16'h7FFF, 1'b1,
        32'h007F_FF00, 32'h0},
      '{8'(LAYOUT_MONO), 8'(FMT_INT32), 16'h8000, 16'h8000, 1'b1,
        32'h8000_0000, 32'h0},
      '{8'(LAYOUT_STEREO), 8'(FMT_INT32), 16'h7FFF, 16'h8000, 1'b1,
        32'h7FFF_0000, 32'h8000_0000},
      '{8'(LAYOUT_STEREO), 8'(FMT_INT24), 16'h8000, 16'h7FFF, 1'b1,
        32'hFF80_0000, 32'h007F_FF00},
      '{8'(LAYOUT_STEREO), 8'(FMT_UNUSED), 16'h1234, 16'hABCD, 1'b1,
        32'h0000_1234, 32'hFFFF_ABCD},
      '{8'(LAYOUT_QUAD), 8'(FMT_INT16), 16'h7FFF, 16'h8000, 1'b0, 32'h0, 32'h0},
      '{8'(LAYOUT_5_1), 8'(FMT_INT24), 16'h1234, 16'hFFFF, 1'b0, 32'h0, 32'h0},
      '{8'(LAYOUT_5_1), 8'(FMT_INT32), 16'h8000, 16'h8000, 1'b0, 32'h0, 32'h0},
      '{8'(LAYOUT_7_1), 8'(FMT_INT32), 16'h7FFF, 16'h8001, 1'b0, 32'h0, 32'h0},
      '{8'(LAYOUT_7_1), 8'(FMT_INT16), 16'h8000, 16'h7FFF, 1'b0, 32'h0, 32'h0},
      '{8'(LAYOUT_UNUSED_5), 8'(FMT_INT16), 16'h0001, 16'h0002, 1'b1,
        32'h0000_0001, 32'h0000_0002},
      '{{5'b11111, LAYOUT_UNUSED_7}, {6'b111111, FMT_INT32}, 16'hFFFF, 16'h0001,
        1'b1, 32'hFFFF_0000, 32'h0001_0000},
      '{8'(LAYOUT_UNUSED_6), 8'(FMT_INT24), 16'h5555, 16'hAAAA, 1'b1,
        32'h0055_5500, 32'hFFAA_AA00},
      '{{5'b10101, LAYOUT_7_1}, {6'b010101, FMT_INT24}, 16'hA5A5, 16'h5A5A,
        1'b0, 32'h0, 32'h0},
      '{8'(LAYOUT_QUAD), {6'b101010, FMT_UNUSED}, 16'h8000, 16'h0000, 1'b0,
        32'h0, 32'h0}
    };

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed frames; the first ones run on the reset settings
    lay_now = 8'(LAYOUT_STEREO);
    fmt_now = 8'(FMT_INT16);
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      if (directed[i].lay_data != lay_now || directed[i].fmt_data != fmt_now) begin
        configure(directed[i].lay_data, directed[i].fmt_data);
        lay_now = directed[i].lay_data;
        fmt_now = directed[i].fmt_data;
      end
      f.left_sample  = directed[i].left;
      f.right_sample = directed[i].right;
      send_frame(f, 0);
      if (directed[i].typed) begin
        item.sample_value  = directed[i].want0;
        item.channel_index = 3'd0;
        item.last_of_frame = (directed[i].lay_data[LAYOUT_W-1:0] == LAYOUT_MONO);
        add_expected(item);
        if (!item.last_of_frame) begin
          item.sample_value  = directed[i].want1;
          item.channel_index = 3'd1;
          item.last_of_frame = 1'b1;
          add_expected(item);
        end
      end else begin
        map_frame(f);
      end
    end

    // Random frames in three idle phases, with settings changed now and then
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 27 : (phase == 1) ? 50 : 0;
      for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
        if (k == 0 || $urandom_range(14) == 0) begin
          junk = 8'($urandom);
          lay  = ($urandom_range(9) < 8) ? 3'($urandom_range(4)) : 3'($urandom_range(7, 5));
          configure({junk[7:3], lay}, 8'($urandom));
        end
        f.left_sample  = rand_sample();
        f.right_sample = ($urandom_range(7) == 0) ? -f.left_sample : rand_sample();
        send_frame(f, idle_pct);
        map_frame(f);
      end
    end

    // Drain and report
    start <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_samples.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/scm_pkg.sv
rtl/core/scm_lane.sv
rtl/core/scm_serializer.sv
rtl/core/stereo_channel_mapper_formatter.sv
tb/sv/tb.sv
